@@ sv/spmf_pkg.sv @@
// ----------------------------------------------------------------------------
// spmf_pkg
// Shared types, codes and defaults for the strict-priority multi-level FIFO.
// ----------------------------------------------------------------------------
package spmf_pkg;

  localparam int MAX_LEVELS_DEF  = 8;
  localparam int LEVEL_DEPTH_DEF = 16;
  localparam int DATA_WIDTH_DEF  = 32;

  // Level fields and the level-count register are fixed at 4 bits
  localparam int LEVEL_W = 4;

  localparam logic [LEVEL_W-1:0] LEVELS_RESET = 4'd8;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DESC = 3'b010,
    S_READ = 3'b100
  } state_t;

endpackage

@@ sv/spmf_prio_enc.sv @@
// ----------------------------------------------------------------------------
// spmf_prio_enc
// Picks the lowest-numbered set request bit.
// ----------------------------------------------------------------------------
module spmf_prio_enc #(
  parameter int N  = 8,
  parameter int IW = 3
) (
  input  logic [N-1:0]  req,
  output logic          found,
  output logic [IW-1:0] idx
);

  always_comb begin
    idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (req[i]) begin
        idx = IW'(i);
      end
    end
  end

  assign found = |req;

endmodule

@@ sv/spmf_desc_store.sv @@
// ----------------------------------------------------------------------------
// spmf_desc_store
// Per-level descriptor memory (head, tail, count) with reset valid bits.
// ----------------------------------------------------------------------------
module spmf_desc_store #(
  parameter int DEPTH = 8,
  parameter int AW    = 3,
  parameter int DW    = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [DW-1:0]    rd_q;
  logic             rd_valid_q;

  // unwritten descriptors read as all zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q       <= mem[raddr];
    rd_valid_q <= valid[raddr];
  end

  assign rdata = rd_valid_q ? rd_q : '0;

endmodule

@@ sv/spmf_entry_ram.sv @@
// ----------------------------------------------------------------------------
// spmf_entry_ram
// Value store, one ring of entries per level, single port, registered read.
// ----------------------------------------------------------------------------
module spmf_entry_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ sv/strict_priority_multi_fifo.sv @@
// ----------------------------------------------------------------------------
// strict_priority_multi_fifo
// Strict-priority queue built from one bounded FIFO ring per level.
// ----------------------------------------------------------------------------
// A rejected enqueue or an all-empty dequeue is answered straight from idle;
// an enqueue passes through S_DESC, a dequeue through S_DESC and S_READ.
// busy covers the descriptor read-modify-write and, on a dequeue, the value
// read, so no new beat is taken while one is in service. done pulses one
// cycle and cannot be stalled. Reset clears the FSM, level flags and descriptor
// valid bits; no clearing pass, the value store is left as it is.
// ----------------------------------------------------------------------------
module strict_priority_multi_fifo
  import spmf_pkg::*;
#(
  parameter int MAX_LEVELS  = MAX_LEVELS_DEF,
  parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_wr_en,
  input  logic [LEVEL_W-1:0]           cfg_wr_data,
  // command side
  input  logic                         start,
  output logic                         busy,
  input  logic                         op,
  input  logic signed [DATA_WIDTH-1:0] value_in,
  input  logic [LEVEL_W-1:0]           level_in,
  // result side
  output logic                         done,
  output logic [1:0]                   status,
  output logic signed [DATA_WIDTH-1:0] value_out,
  output logic [LEVEL_W-1:0]           level_out
);

  // level index, pointer, count and address widths
  localparam int LIW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int PTR_W  = $clog2(LEVEL_DEPTH);
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int DESC_W = 2 * PTR_W + CNT_W;
  localparam int ENT_N  = MAX_LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W = $clog2(ENT_N);
  // common width for comparing levels against the level count
  localparam int LCW    = ($clog2(MAX_LEVELS + 1) > LEVEL_W) ? $clog2(MAX_LEVELS + 1)
                                                             : LEVEL_W;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t                  state, state_next;
  logic [LEVEL_W-1:0]      levels_in_use;
  logic [MAX_LEVELS-1:0]   nonempty;           // one flag per level, drives the encoder
  op_t                     op_r;
  logic [DATA_WIDTH-1:0]   val_r;
  logic [LIW-1:0]          q_r;                // level index in service

  logic                    done_r, done_next;
  status_t                 status_r, status_next;
  logic [DATA_WIDTH-1:0]   vout_r, vout_next;
  logic [LEVEL_W-1:0]      lout_r, lout_next;

  // --------------------------------------------------------------------------
  // Level selection
  // --------------------------------------------------------------------------
  logic [LCW-1:0]          eff_levels;
  logic [MAX_LEVELS-1:0]   level_mask;
  logic                    enq_ok;
  logic [LIW-1:0]          enq_q;
  logic                    deq_found;
  logic [LIW-1:0]          deq_q;
  logic                    accept;

  always_comb begin
    if (LCW'(levels_in_use) > LCW'(MAX_LEVELS)) begin
      eff_levels = LCW'(MAX_LEVELS);
    end else begin
      eff_levels = LCW'(levels_in_use);
    end
    for (int i = 0; i < MAX_LEVELS; i++) begin
      level_mask[i] = (LCW'(i) < eff_levels);
    end
  end

  // level 0 and anything beyond the effective count are rejected
  assign enq_ok = (level_in != '0) && (LCW'(level_in) <= eff_levels);
  assign enq_q  = LIW'(level_in - 1'b1);
  assign accept = start && !busy;

  spmf_prio_enc #(
    .N  (MAX_LEVELS),
    .IW (LIW)
  ) u_prio_enc (
    .req   (nonempty & level_mask),
    .found (deq_found),
    .idx   (deq_q)
  );

  // --------------------------------------------------------------------------
  // Descriptor memory: read issued on accept, written back in S_DESC
  // --------------------------------------------------------------------------
  logic [LIW-1:0]    desc_raddr;
  logic [DESC_W-1:0] desc_rdata;
  logic              desc_we;
  logic [DESC_W-1:0] desc_wdata;
  logic [PTR_W-1:0]  d_head, d_tail;
  logic [CNT_W-1:0]  d_cnt;
  logic [PTR_W-1:0]  head_inc, tail_inc;

  assign desc_raddr = (op_t'(op) == OP_ENQ) ? enq_q : deq_q;

  spmf_desc_store #(
    .DEPTH (MAX_LEVELS),
    .AW    (LIW),
    .DW    (DESC_W)
  ) u_desc_store (
    .clk   (clk),
    .rst   (rst),
    .raddr (desc_raddr),
    .rdata (desc_rdata),
    .we    (desc_we),
    .waddr (q_r),
    .wdata (desc_wdata)
  );

  assign {d_head, d_tail, d_cnt} = desc_rdata;

  // ring pointers wrap at the level depth, which need not be a power of two
  assign head_inc = (d_head == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : d_head + 1'b1;
  assign tail_inc = (d_tail == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : d_tail + 1'b1;

  // --------------------------------------------------------------------------
  // Value store
  // --------------------------------------------------------------------------
  logic                  ent_we, ent_re;
  logic [ADDR_W-1:0]     ent_addr;
  logic [ADDR_W-1:0]     ent_base;
  logic [DATA_WIDTH-1:0] ent_rdata;

  assign ent_base = ADDR_W'(q_r) * ADDR_W'(LEVEL_DEPTH);

  spmf_entry_ram #(
    .DEPTH (ENT_N),
    .AW    (ADDR_W),
    .DW    (DATA_WIDTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .re    (ent_re),
    .addr  (ent_addr),
    .wdata (val_r),
    .rdata (ent_rdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic ne_set, ne_clr;

  always_comb begin
    state_next  = state;
    done_next   = 1'b0;
    status_next = status_r;
    vout_next   = vout_r;
    lout_next   = lout_r;
    desc_we     = 1'b0;
    desc_wdata  = desc_rdata;
    ent_we      = 1'b0;
    ent_re      = 1'b0;
    ent_addr    = ent_base + ADDR_W'(d_tail);
    ne_set      = 1'b0;
    ne_clr      = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (op_t'(op) == OP_ENQ) begin
            if (enq_ok) begin
              state_next = S_DESC;
            end else begin
              done_next   = 1'b1;
              status_next = ST_INVALID;
              vout_next   = '0;
              lout_next   = '0;
            end
          end else begin
            if (deq_found) begin
              state_next = S_DESC;
            end else begin
              done_next   = 1'b1;
              status_next = ST_EMPTY;
              vout_next   = '1;
              lout_next   = '0;
            end
          end
        end
      end
      S_DESC: begin
        if (op_r == OP_ENQ) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
          vout_next  = '0;
          lout_next  = '0;
          if (d_cnt == CNT_W'(LEVEL_DEPTH)) begin
            status_next = ST_FULL;
          end else begin
            status_next = ST_OK;
            ent_we      = 1'b1;
            ent_addr    = ent_base + ADDR_W'(d_tail);
            desc_we     = 1'b1;
            desc_wdata  = {d_head, tail_inc, d_cnt + 1'b1};
            ne_set      = 1'b1;
          end
        end else begin
          state_next = S_READ;
          ent_re     = 1'b1;
          ent_addr   = ent_base + ADDR_W'(d_head);
          desc_we    = 1'b1;
          desc_wdata = {head_inc, d_tail, d_cnt - 1'b1};
          ne_clr     = (d_cnt == CNT_W'(1));
        end
      end
      S_READ: begin
        state_next  = S_IDLE;
        done_next   = 1'b1;
        status_next = ST_OK;
        vout_next   = ent_rdata;
        lout_next   = LEVEL_W'(q_r) + 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done_r        <= 1'b0;
      levels_in_use <= LEVELS_RESET;
      nonempty      <= '0;
    end else begin
      state  <= state_next;
      done_r <= done_next;
      if (cfg_wr_en) begin
        levels_in_use <= cfg_wr_data;
      end
      if (ne_set) begin
        nonempty[q_r] <= 1'b1;
      end else if (ne_clr) begin
        nonempty[q_r] <= 1'b0;
      end
    end
  end

  // command capture and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op_t'(op);
      val_r <= value_in;
      q_r   <= desc_raddr;
    end
    status_r <= status_next;
    vout_r   <= vout_next;
    lout_r   <= lout_next;
  end

  assign busy      = (state != S_IDLE);
  assign done      = done_r;
  assign status    = status_r;
  assign value_out = vout_r;
  assign level_out = lout_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_progress : assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy || done))
    else $error("accepted beat neither in service nor answered");

  a_empty_result : assert property (@(posedge clk) disable iff (rst)
    (done && status_r == ST_EMPTY) |-> (value_out == '1 && level_out == '0))
    else $error("empty dequeue with wrong payload");

  a_reject_result : assert property (@(posedge clk) disable iff (rst)
    (done && (status_r == ST_INVALID || status_r == ST_FULL))
      |-> (value_out == '0 && level_out == '0))
    else $error("rejected enqueue with non-zero payload");

  a_no_done_while_busy : assert property (@(posedge clk) disable iff (rst)
    (state == S_DESC && op_r == OP_DEQ) |=> (busy && !done))
    else $error("dequeue answered before value read");

endmodule

@@ dv/strict_priority_multi_fifo_checker.sv @@
// ----------------------------------------------------------------------------
// strict_priority_multi_fifo_checker
// Watches the command, result and configuration ports of the priority queue.
// It keeps its own per-level rings, works out the reply owed to every
// accepted command and compares each done beat with the oldest one.
// ----------------------------------------------------------------------------
module strict_priority_multi_fifo_checker
  import spmf_pkg::*;
#(
  parameter int MAX_LEVELS  = MAX_LEVELS_DEF,
  parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [LEVEL_W-1:0]           cfg_wr_data,
  input  logic                         start,
  input  logic                         busy,
  input  logic                         op,
  input  logic signed [DATA_WIDTH-1:0] value_in,
  input  logic [LEVEL_W-1:0]           level_in,
  input  logic                         done,
  input  logic [1:0]                   status,
  input  logic signed [DATA_WIDTH-1:0] value_out,
  input  logic [LEVEL_W-1:0]           level_out,
  output int                           error_count,
  output int                           replies_owed,
  output int                           replies_seen,
  output int                           full_seen,
  output int                           empty_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t                         st;
    logic signed [DATA_WIDTH-1:0]    val;
    logic [LEVEL_W-1:0]              lvl;
  } reply_t;

  reply_t                       replies_due[$];
  logic signed [DATA_WIDTH-1:0] ring [MAX_LEVELS][LEVEL_DEPTH];
  int                           head [MAX_LEVELS];
  int                           tail [MAX_LEVELS];
  int                           fill [MAX_LEVELS];
  logic [LEVEL_W-1:0]           levels_reg;

  // Enqueue or dequeue against the shadow rings and return the reply owed
  function automatic reply_t apply_command(op_t o, logic signed [DATA_WIDTH-1:0] v,
                                           logic [LEVEL_W-1:0] l);
    reply_t r;
    int     n;
    int     q;
    bit     found;
    r.st  = ST_OK;
    r.val = '0;
    r.lvl = '0;
    n     = (int'(levels_reg) > MAX_LEVELS) ? MAX_LEVELS : int'(levels_reg);
    found = 1'b0;
    if (o == OP_ENQ) begin
      q = int'(l) - 1;
      if (l == '0 || int'(l) > n) begin
        r.st = ST_INVALID;
      end else if (fill[q] >= LEVEL_DEPTH) begin
        r.st = ST_FULL;
      end else begin
        ring[q][tail[q]] = v;
        tail[q] = (tail[q] + 1) % LEVEL_DEPTH;
        fill[q]++;
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        if (!found && fill[i] != 0) begin
          r.val   = ring[i][head[i]];
          head[i] = (head[i] + 1) % LEVEL_DEPTH;
          fill[i]--;
          r.lvl   = LEVEL_W'(i + 1);
          found   = 1'b1;
        end
      end
      if (!found) begin
        r.st  = ST_EMPTY;
        r.val = '1;
      end
    end
    return r;
  endfunction

  task automatic check_reply();
    reply_t e;
    if (replies_due.size() == 0) begin
      $error("done beat with no command outstanding: status %0d value %0d level %0d",
             status, value_out, level_out);
      error_count++;
      return;
    end
    e = replies_due.pop_front();
    if (status !== e.st) begin
      $error("status: expected %0d, got %0d", e.st, status);
      error_count++;
    end
    if (value_out !== e.val) begin
      $error("value_out: expected %0d, got %0d", e.val, value_out);
      error_count++;
    end
    if (level_out !== e.lvl) begin
      $error("level_out: expected %0d, got %0d", e.lvl, level_out);
      error_count++;
    end
    if (e.st == ST_FULL)  full_seen++;
    if (e.st == ST_EMPTY) empty_seen++;
    replies_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      replies_due.delete();
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head[i] = 0;
        tail[i] = 0;
        fill[i] = 0;
      end
      levels_reg   = LEVELS_RESET;
      replies_owed = 0;
    end else begin
      // result first, so a beat accepted on the same edge queues behind it
      if (done) check_reply();
      // a beat taken on the edge of a register write still sees the old count
      if (start && !busy) replies_due.push_back(apply_command(op_t'(op), value_in, level_in));
      if (cfg_wr_en) levels_reg = cfg_wr_data;
      replies_owed = replies_due.size();
    end
  end

endmodule

@@ dv/strict_priority_multi_fifo_test.sv @@
// ----------------------------------------------------------------------------
// strict_priority_multi_fifo_test
// Drives enqueue and dequeue commands into the strict-priority queue over a
// range of level-count settings, with random gaps on the command side.
// Checking is done by the checker beside the block; this top only makes
// stimulus, runs the watchdog and gives the verdict.
// ----------------------------------------------------------------------------
module strict_priority_multi_fifo_test;
  timeunit 1ns;
  timeprecision 1ps;
  import spmf_pkg::*;

  localparam int DW          = DATA_WIDTH_DEF;
  localparam int NUM_PHASES  = 9;
  // leave a margin after the longest beat before touching the register
  localparam int SETTLE      = 6;
  // idle cycles with nothing accepted or answered before the run is called hung
  localparam int STALL_LIMIT = 2000;

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 cfg_wr_en   = 1'b0;
  logic [LEVEL_W-1:0]   cfg_wr_data = LEVELS_RESET;
  logic                 start       = 1'b0;
  logic                 op          = OP_ENQ;
  logic signed [DW-1:0] value_in    = '0;
  logic [LEVEL_W-1:0]   level_in    = '0;
  logic                 busy;
  logic                 done;
  logic [1:0]           status;
  logic signed [DW-1:0] value_out;
  logic [LEVEL_W-1:0]   level_out;

  int error_count;
  int replies_owed;
  int replies_seen;
  int full_seen;
  int empty_seen;
  int commands_sent;
  int stall_cycles;

  always #2 clk = ~clk;

  strict_priority_multi_fifo dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .value_in   (value_in),
    .level_in   (level_in),
    .done       (done),
    .status     (status),
    .value_out  (value_out),
    .level_out  (level_out)
  );

  strict_priority_multi_fifo_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .value_in    (value_in),
    .level_in    (level_in),
    .done        (done),
    .status      (status),
    .value_out   (value_out),
    .level_out   (level_out),
    .error_count (error_count),
    .replies_owed(replies_owed),
    .replies_seen(replies_seen),
    .full_seen   (full_seen),
    .empty_seen  (empty_seen)
  );

  // Watchdog: any accepted command or any done beat counts as progress.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("strict_priority_multi_fifo_test: done, errors");
        $finish;
      end
    end
  end

  // One command beat. Fields change on the falling edge; the beat is taken
  // on the first rising edge that sees busy low. busy is read straight after
  // the edge, so it still holds the value the block saw.
  task automatic send_command(op_t o, logic signed [DW-1:0] v, logic [LEVEL_W-1:0] l);
    @(negedge clk);
    start    <= 1'b1;
    op       <= o;
    value_in <= v;
    level_in <= l;
    do @(posedge clk); while (busy);
    commands_sent++;
  endtask

  // Geometric gap: each further idle cycle with the given chance in a hundred.
  task automatic sender_gap(int pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Register writes only once every reply is back and the block has settled.
  // Every command gets a reply, so an empty reply queue plus a short pause
  // means nothing is in flight.
  task automatic write_levels(logic [LEVEL_W-1:0] n);
    @(negedge clk);
    start <= 1'b0;
    while (replies_owed != 0 || busy) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Values lean on the two's-complement extremes, -1 and zero.
  function automatic logic signed [DW-1:0] pick_value();
    case ($urandom_range(7))
      0:       return {1'b0, {(DW-1){1'b1}}};
      1:       return {1'b1, {(DW-1){1'b0}}};
      2:       return '1;
      3:       return '0;
      default: return DW'($urandom);
    endcase
  endfunction

  // Mostly a level in range; now and then any 4-bit code, which covers
  // level zero and levels above the count.
  function automatic logic [LEVEL_W-1:0] pick_level(int eff);
    if (eff == 0 || $urandom_range(99) < 12) return LEVEL_W'($urandom_range(15));
    return LEVEL_W'($urandom_range(eff, 1));
  endfunction

  initial begin
    // per-phase level count, command count and share of enqueues;
    // 15 saturates, 0 rejects everything, dropping to 1 strands upper levels
    int unsigned     levels_tab [NUM_PHASES] = '{8, 1, 15, 0, 4, 2, 9, 0, 8};
    int              count_tab  [NUM_PHASES] = '{220, 200, 220, 40, 220, 200, 220, 200, 230};
    int              enq_tab    [NUM_PHASES] = '{65, 70, 35, 50, 70, 40, 60, 50, 45};
    int              idle_pct;
    int              eff;
    logic [LEVEL_W-1:0] lv;

    commands_sent = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // ---- directed: reset count of 8 levels ----
    send_command(OP_DEQ, '0, 4'd0);              // nothing held: all empty
    send_command(OP_ENQ, 32'sd5, 4'd0);          // level zero rejected
    send_command(OP_ENQ, 32'sd6, 4'd9);          // above the count
    send_command(OP_ENQ, 32'sh7fffffff, 4'd8);   // most positive, lowest priority
    send_command(OP_ENQ, 32'sh80000000, 4'd1);   // most negative, highest priority
    send_command(OP_DEQ, '0, 4'd15);             // level 1 first
    send_command(OP_DEQ, '0, 4'd0);              // then level 8
    // fill level 2 to its depth, then one more is refused as full
    for (int i = 0; i < LEVEL_DEPTH_DEF; i++) begin
      send_command(OP_ENQ, DW'(1) << (2 * i), 4'd2);
    end
    send_command(OP_ENQ, 32'sh5a5a5a5a, 4'd2);

    // ---- random phases ----
    for (int p = 0; p < NUM_PHASES; p++) begin
      lv = (p == 7) ? LEVEL_W'($urandom_range(7, 1)) : LEVEL_W'(levels_tab[p]);
      write_levels(lv);
      eff      = (int'(lv) > MAX_LEVELS_DEF) ? MAX_LEVELS_DEF : int'(lv);
      idle_pct = (p < 3) ? 25 : (p < 6) ? 46 : 0;
      for (int k = 0; k < count_tab[p]; k++) begin
        sender_gap(idle_pct);
        if ($urandom_range(99) < enq_tab[p])
          send_command(OP_ENQ, pick_value(), pick_level(eff));
        else
          send_command(OP_DEQ, pick_value(), LEVEL_W'($urandom_range(15)));
      end
    end

    // ---- drain: wait for every reply, then a few more cycles ----
    @(negedge clk);
    start <= 1'b0;
    while (replies_owed != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("covered %0d commands over %0d level-count settings, %0d replies checked",
             commands_sent, NUM_PHASES + 1, replies_seen);
    $display("full refusals seen %0d, all-empty dequeues seen %0d", full_seen, empty_seen);
    if (error_count == 0) begin
      $display("strict_priority_multi_fifo_test: done, clean");
    end else begin
      $display("strict_priority_multi_fifo_test: done, errors");
    end
    $finish;
  end

endmodule
